/* rtl/cigar_coverage_accumulator_top_assert.svh */
// ----------------------------------------------------------------------------
// Coverage accumulator assertion macros
// Concurrent check helpers clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIGAR_COVERAGE_ACCUMULATOR_TOP_ASSERT_SVH
`define CIGAR_COVERAGE_ACCUMULATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CCOV_ASSERT_HOLD(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("coverage accumulator check failed");

`define CCOV_ASSERT_IMPLY(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("coverage accumulator check failed");

`define CCOV_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("coverage accumulator check failed");

`else

`define CCOV_ASSERT_HOLD(label, expr)
`define CCOV_ASSERT_IMPLY(label, cause, effect)
`define CCOV_ASSERT_NEXT(label, cause, effect)

`endif

`endif

/* rtl/ccov_pkg.sv */
// ----------------------------------------------------------------------------
// ccov_pkg
// Shared types, sizes and codes of the coverage accumulator.
// ----------------------------------------------------------------------------
package ccov_pkg;

    localparam int NUM_REFERENCES   = 4;
    localparam int REFERENCE_LENGTH = 65536;
    localparam int COUNT_WIDTH      = 16;

    localparam int STORE_DEPTH = NUM_REFERENCES * REFERENCE_LENGTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CURSOR_W    = $clog2(REFERENCE_LENGTH + 1);
    localparam int LEN_W       = 16;
    localparam int WALK_W      = ((CURSOR_W > LEN_W) ? CURSOR_W : LEN_W) + 1;

    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_APPLY = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [3:0] OP_M  = 4'd0;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_N  = 4'd3;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X  = 4'd8;

    localparam logic [1:0] STRAND_BOTH    = 2'd0;
    localparam logic [1:0] STRAND_FORWARD = 2'd1;
    localparam logic [1:0] STRAND_REVERSE = 2'd2;

    localparam logic REG_STRAND_MODE = 1'b0;

    typedef struct packed {
        logic [1:0]       action;
        logic [1:0]       ref_id;
        logic [15:0]      base_position;
        logic             reverse_strand;
        logic [3:0]       op_code;
        logic [LEN_W-1:0] op_length;
    } item_t;

    typedef struct packed {
        logic [15:0] coverage_count;
        logic        out_of_range;
        logic        saturated;
    } result_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic exec;
        logic walk_rd;
        logic walk_wr;
        logic walk_done;
        logic read_capture;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_walk;
        logic need_read;
        logic walk_end;
        logic slot_free;
    } status_t;

endpackage

/* rtl/cigar_coverage_accumulator_top.sv */
// ----------------------------------------------------------------------------
// cigar_coverage_accumulator_top
// Per-base alignment coverage counter driven by decoded CIGAR words.
// ----------------------------------------------------------------------------
// After reset the block sweeps all NUM_REFERENCES * REFERENCE_LENGTH store
// entries (262144 as built) to zero, one entry per cycle, and stalls the
// item channel until the sweep ends; the register port works throughout.
// Each item then returns one result word. A begin word, a non-counting op
// word, an out-of-range read or an unknown action passes from acceptance
// through the exec and finish states; an in-range read adds a read-wait
// state between exec and finish, and a counting op word walks its bases in
// read/write state pairs before finish: every base is a read-modify-write
// on the single-port store. The result word is loaded in the finish state.
// A finished word also waits while the previous result word is stalled. The
// next word is accepted while a result still waits. strand_mode sits at
// byte address 0 and is sampled by begin words.
// ----------------------------------------------------------------------------
module cigar_coverage_accumulator_top
    import ccov_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    logic [1:0] strand_mode_reg;
    logic       cfg_write;
    cmd_t       cmd;
    status_t    status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_STRAND_MODE);
    assign prdata    = (paddr[2] == REG_STRAND_MODE) ? {30'd0, strand_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strand_mode_reg <= STRAND_BOTH;
        end
        else if (cfg_write)
        begin
            strand_mode_reg <= pwdata[1:0];
        end
    end

    ccov_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ccov_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .strand_mode  (strand_mode_reg),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`include "cigar_coverage_accumulator_top_assert.svh"

    `CCOV_ASSERT_IMPLY(a_clear_blocks_items, cmd.clr_step, item_stall)
    `CCOV_ASSERT_NEXT(a_accept_then_busy, item_valid && !item_stall, item_stall)
    `CCOV_ASSERT_IMPLY(a_push_slot_free, cmd.push, !result_valid || !result_stall)
    `CCOV_ASSERT_NEXT(a_read_then_write, cmd.walk_rd, cmd.walk_wr)

endmodule

/* rtl/ccov_ctrl.sv */
// ----------------------------------------------------------------------------
// ccov_ctrl
// Sequencer: clearing pass, item intake, base walk and result hand-off.
// ----------------------------------------------------------------------------
module ccov_ctrl
    import ccov_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (status.need_walk)
                begin
                    state_next = ST_WALK_RD;
                end
                else if (status.need_read)
                begin
                    state_next = ST_READ_WAIT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_WALK_RD:
            begin
                if (status.walk_end)
                begin
                    cmd.walk_done = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = ST_WALK_WR;
                end
            end
            ST_WALK_WR:
            begin
                cmd.walk_wr = 1'b1;
                state_next  = ST_WALK_RD;
            end
            ST_READ_WAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.slot_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign item_stall = (state_reg != ST_IDLE);

endmodule

/* rtl/ccov_datapath.sv */
// ----------------------------------------------------------------------------
// ccov_datapath
// Coverage store, alignment cursor, walk counter and result register.
// ----------------------------------------------------------------------------
module ccov_datapath
    import ccov_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    status,
    input  logic [1:0] strand_mode,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] store_mem [STORE_DEPTH];
    logic [COUNT_WIDTH-1:0] rdata_reg;

    logic [ADDR_W-1:0]      clr_cnt_reg;
    item_t                  item_reg;
    logic [CURSOR_W-1:0]    cursor_reg;
    logic [1:0]             cur_ref_reg;
    logic                   count_en_reg;
    logic [LEN_W-1:0]       walk_cnt_reg;
    logic [15:0]            res_count_reg;
    logic                   res_oor_reg;
    logic                   res_sat_reg;
    logic                   result_valid_reg;
    result_t                result_reg;

    logic                   ref_ok;
    logic                   pos_ok;
    logic                   strand_ok;
    logic                   match_op;
    logic                   skip_op;
    logic [WALK_W-1:0]      walk_pos;
    logic [WALK_W-1:0]      op_end;
    logic [CURSOR_W-1:0]    op_end_sat;
    logic                   walk_past;
    logic                   walk_len_done;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    function automatic logic [ADDR_W-1:0] store_addr(logic [1:0] r, logic [WALK_W-1:0] p);
        return ADDR_W'(r) * ADDR_W'(REFERENCE_LENGTH) + ADDR_W'(p);
    endfunction

    assign ref_ok    = (item_reg.ref_id < NUM_REFERENCES);
    assign pos_ok    = (item_reg.base_position < REFERENCE_LENGTH);
    assign strand_ok = (strand_mode == STRAND_BOTH) ||
                       (strand_mode == STRAND_FORWARD && !item_reg.reverse_strand) ||
                       (strand_mode == STRAND_REVERSE && item_reg.reverse_strand);
    assign match_op  = (item_reg.op_code == OP_M) || (item_reg.op_code == OP_EQ) ||
                       (item_reg.op_code == OP_X);
    assign skip_op   = (item_reg.op_code == OP_D) || (item_reg.op_code == OP_N);

    assign walk_pos      = WALK_W'(cursor_reg) + WALK_W'(walk_cnt_reg);
    assign op_end        = WALK_W'(cursor_reg) + WALK_W'(item_reg.op_length);
    assign op_end_sat    = (op_end < REFERENCE_LENGTH) ? CURSOR_W'(op_end)
                                                       : CURSOR_W'(REFERENCE_LENGTH);
    assign walk_len_done = (walk_cnt_reg == item_reg.op_length);
    assign walk_past     = (walk_pos >= REFERENCE_LENGTH);
    assign count_inc     = (rdata_reg < COUNT_MAX) ? rdata_reg + 1'b1 : rdata_reg;

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));
    assign status.need_walk  = (item_reg.action == ACT_APPLY) && match_op && count_en_reg &&
                               (cur_ref_reg < NUM_REFERENCES);
    assign status.need_read  = (item_reg.action == ACT_READ) && ref_ok && pos_ok;
    assign status.walk_end   = walk_len_done || walk_past;
    assign status.slot_free  = !result_valid_reg || !result_stall;

    always_comb
    begin
        mem_we    = cmd.clr_step || cmd.walk_wr;
        mem_re    = (cmd.exec && status.need_read) || cmd.walk_rd;
        mem_wdata = cmd.clr_step ? '0 : count_inc;
        priority if (cmd.clr_step)
        begin
            mem_addr = clr_cnt_reg;
        end
        else if (cmd.exec)
        begin
            mem_addr = store_addr(item_reg.ref_id, WALK_W'(item_reg.base_position));
        end
        else
        begin
            mem_addr = store_addr(cur_ref_reg, walk_pos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg      <= '0;
            cursor_reg       <= '0;
            cur_ref_reg      <= '0;
            count_en_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                if (item_reg.action == ACT_BEGIN)
                begin
                    cur_ref_reg  <= item_reg.ref_id;
                    cursor_reg   <= pos_ok ? CURSOR_W'(item_reg.base_position)
                                           : CURSOR_W'(REFERENCE_LENGTH);
                    count_en_reg <= ref_ok && strand_ok;
                end
                else if (item_reg.action == ACT_APPLY && !status.need_walk &&
                         (match_op || skip_op))
                begin
                    cursor_reg <= op_end_sat;
                end
            end
            if (cmd.walk_done)
            begin
                cursor_reg <= op_end_sat;
            end
            if (cmd.push)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            walk_cnt_reg  <= '0;
            res_count_reg <= '0;
            res_sat_reg   <= 1'b0;
            unique case (item_reg.action)
                ACT_BEGIN: res_oor_reg <= !ref_ok;
                ACT_READ:  res_oor_reg <= !(ref_ok && pos_ok);
                default:   res_oor_reg <= 1'b0;
            endcase
        end
        if (cmd.walk_wr)
        begin
            walk_cnt_reg <= walk_cnt_reg + 1'b1;
            if (count_inc == COUNT_MAX)
            begin
                res_sat_reg <= 1'b1;
            end
        end
        if (cmd.walk_done && !walk_len_done)
        begin
            res_oor_reg <= 1'b1;
        end
        if (cmd.read_capture)
        begin
            res_count_reg <= 16'(rdata_reg);
        end
        if (cmd.push)
        begin
            result_reg.coverage_count <= res_count_reg;
            result_reg.out_of_range   <= res_oor_reg;
            result_reg.saturated      <= res_sat_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
